[hw/rtl/kaq_pkg.sv]
// Shared types and constants for the key auto-repeat event queue.
package kaq_pkg;

  localparam int ACT_W        = 3;
  localparam int LEVEL_W      = 5;
  localparam int HOLD_W       = 9;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam int NUM_ACTIONS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [CFG_DATA_W-1:0] DELAY_RESET    = 8'd30;
  localparam logic [CFG_DATA_W-1:0] INTERVAL_RESET = 8'd4;
  localparam logic [HOLD_W-1:0]     HOLD_MAX       = '1;

  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_HALT      = 2'd3;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_POP     = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             command;
    logic [ACT_W-1:0] key_action;
    logic             key_mapped;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action_out;
    logic               action_valid;
    logic [LEVEL_W-1:0] queue_level;
    logic               overflow_seen;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic exec;
    logic scan_step;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic run_scan;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

[hw/rtl/kaq_ctrl.sv]
// Sequencing state machine for the key auto-repeat event queue.
module kaq_ctrl
  import kaq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.run_scan ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The result waits here until the output register is free.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_EXEC)
    else $error("accepted beat did not start execution");

  a_scan_continues: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && !stat.scan_last |=> state == ST_SCAN)
    else $error("counter scan ended early");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == ST_IDLE && !cmd.out_load)
    else $error("result loaded more than once");
`endif

endmodule

[hw/rtl/kaq_dp.sv]
// Datapath: configuration, hold counters, repeat pacer, action queue and result register.
module kaq_dp
  import kaq_pkg::*;
#(
  parameter int NUM_ACTIONS = NUM_ACTIONS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int IDX_W  = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_ACTIONS - 1);
  localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] repeat_delay;
  logic [CFG_DATA_W-1:0] repeat_interval;
  logic                  map_mode;
  logic                  input_halt;

  // Latched item.
  cmd_t             cmd_q;
  logic [ACT_W-1:0] act_q;
  logic             mapped_q;

  logic [HOLD_W-1:0] hold [NUM_ACTIONS];
  logic [HOLD_W-1:0] pacer;
  logic [IDX_W-1:0]  scan_idx;

  logic [ACT_W-1:0]  mem [QUEUE_DEPTH];
  logic [ACT_W-1:0]  rd_data;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [FILL_W-1:0] fill;

  logic [ACT_W-1:0] res_action;
  logic             res_valid;
  logic             dropped;

  logic              key_ok;
  logic [IDX_W-1:0]  sel_idx;
  logic [HOLD_W-1:0] hold_sel;
  logic              hold_we;
  logic [HOLD_W-1:0] hold_wdata;
  logic              push_en;
  logic [ACT_W-1:0]  push_data;
  logic              pop_en;
  logic              pacer_we;
  logic [HOLD_W-1:0] pacer_next;
  logic              drop_set;
  logic              queue_full;

  assign key_ok     = mapped_q && (32'(act_q) < NUM_ACTIONS);
  assign sel_idx    = cmd.scan_step ? scan_idx : IDX_W'(act_q);
  assign hold_sel   = hold[sel_idx];
  assign queue_full = (fill == FULL_FILL);

  always_comb begin
    hold_we    = 1'b0;
    hold_wdata = hold_sel;
    push_en    = 1'b0;
    push_data  = act_q;
    pop_en     = 1'b0;
    pacer_we   = 1'b0;
    pacer_next = pacer;
    drop_set   = 1'b0;
    if (cmd.exec) begin
      case (cmd_q)
        CMD_POP: pop_en = (fill != '0);
        CMD_PRESS: begin
          if (!input_halt && key_ok && hold_sel == '0 && fill == '0) begin
            push_en    = 1'b1;
            hold_we    = 1'b1;
            hold_wdata = HOLD_W'(1);
          end
        end
        CMD_RELEASE: begin
          if (!input_halt && key_ok) begin
            hold_we    = 1'b1;
            hold_wdata = '0;
          end
        end
        default: ;
      endcase
    end else if (cmd.scan_step) begin
      push_data = ACT_W'(scan_idx);
      if (hold_sel > HOLD_W'(repeat_delay)) begin
        pacer_we = 1'b1;
        if (pacer > HOLD_W'(repeat_interval)) begin
          // A repeat is due; on a full queue it is dropped but the pacer still restarts.
          pacer_next = '0;
          push_en    = !queue_full;
          drop_set   = queue_full;
        end else if (pacer != HOLD_MAX) begin
          pacer_next = pacer + HOLD_W'(1);
        end
      end else if (hold_sel != '0 && hold_sel != HOLD_MAX) begin
        hold_we    = 1'b1;
        hold_wdata = hold_sel + HOLD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay    <= DELAY_RESET;
      repeat_interval <= INTERVAL_RESET;
      map_mode        <= 1'b0;
      input_halt      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REPEAT_DELAY:    repeat_delay    <= cfg_data;
        REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        REG_MAP_MODE:        map_mode        <= cfg_data[0];
        REG_INPUT_HALT:      input_halt      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_q    <= in_data.command;
      act_q    <= in_data.key_action;
      mapped_q <= in_data.key_mapped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ACTIONS; i++) begin
        hold[i] <= '0;
      end
      pacer    <= '0;
      scan_idx <= '0;
      head     <= '0;
      tail     <= '0;
      fill     <= '0;
      dropped  <= 1'b0;
    end else begin
      if (hold_we) begin
        hold[sel_idx] <= hold_wdata;
      end
      if (pacer_we) begin
        pacer <= pacer_next;
      end
      if (cmd.load_item) begin
        scan_idx <= '0;
        dropped  <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
        if (drop_set) begin
          dropped <= 1'b1;
        end
      end
      if (push_en) begin
        tail <= (tail == LAST_PTR) ? '0 : tail + PTR_W'(1);
      end
      if (pop_en) begin
        head <= (head == LAST_PTR) ? '0 : head + PTR_W'(1);
      end
      if (push_en && !pop_en) begin
        fill <= fill + FILL_W'(1);
      end else if (pop_en && !push_en) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  // Queue storage; the read port follows the head pointer.
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[tail] <= push_data;
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      res_action <= '0;
      res_valid  <= 1'b0;
    end else if (pop_en) begin
      res_action <= rd_data;
      res_valid  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.action_out    <= res_action;
      out_data.action_valid  <= res_valid;
      out_data.queue_level   <= LEVEL_W'(fill);
      out_data.overflow_seen <= dropped;
    end
  end

  assign stat.run_scan  = (cmd_q == CMD_TICK) && !input_halt && !(map_mode && fill != '0);
  assign stat.scan_last = (scan_idx == LAST_IDX);
  assign stat.out_free  = !out_valid || out_ready;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_FILL)
    else $error("queue fill above depth");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    dropped |-> queue_full)
    else $error("overflow flagged on a queue that is not full");

  a_pop_decrements: assert property (@(posedge clk) disable iff (rst)
    pop_en |=> fill == $past(fill) - FILL_W'(1))
    else $error("pop did not reduce the fill");
`endif

endmodule

[hw/rtl/key_autorepeat_event_queue.sv]
// Top level of the key auto-repeat event queue.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  in       | input     | in_valid / in_ready     | in_data (command, key, mapped)
//  out      | output    | out_valid / out_ready   | out_data (action, level, flags)
//  cfg      | input     | cfg_we                  | cfg_index, cfg_data
//
// Press, release, pop and skipped tick beats pass from acceptance through the execute and
// finish states to the output register; a running tick also passes through the scan state,
// which steps one hold counter per cycle over all NUM_ACTIONS counters before finishing.
// One beat at a time; the next is accepted once the result has moved to the output register.
// A stalled output keeps the controller in its finish state with the result in the datapath.
// Reset is synchronous and clears counters, pointers and configuration; the queue needs none.
module key_autorepeat_event_queue
  import kaq_pkg::*;
#(
  parameter int NUM_ACTIONS = NUM_ACTIONS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kaq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kaq_dp #(
    .NUM_ACTIONS (NUM_ACTIONS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
